>>> src/siex_pkg.sv
package siex_pkg;

	// Item kinds on the input channel.
	localparam logic ITEM_START = 1'b0;
	localparam logic ITEM_READ  = 1'b1;

	// Access kinds on the output channel.
	localparam logic [1:0] ACC_READ  = 2'd0;
	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_ERROR = 2'd2;

	// Instruction phases.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_OPLO  = 3'd1;
	localparam logic [2:0] PH_OPHI  = 3'd2;
	localparam logic [2:0] PH_PTRLO = 3'd3;
	localparam logic [2:0] PH_PTRHI = 3'd4;

	// Addressing modes.
	localparam logic [2:0] M_ZP   = 3'd0;
	localparam logic [2:0] M_ZPI  = 3'd1;
	localparam logic [2:0] M_ABS  = 3'd2;
	localparam logic [2:0] M_ABSI = 3'd3;
	localparam logic [2:0] M_INDX = 3'd4;
	localparam logic [2:0] M_INDY = 3'd5;

	// Register selects.
	localparam logic [1:0] REG_A    = 2'd0;
	localparam logic [1:0] REG_X    = 2'd1;
	localparam logic [1:0] REG_Y    = 2'd2;
	localparam logic [1:0] REG_NONE = 2'd0;

	// Store opcodes.
	localparam logic [7:0] OP_STA_ZP   = 8'h85;
	localparam logic [7:0] OP_STA_ZPX  = 8'h95;
	localparam logic [7:0] OP_STA_ABS  = 8'h8D;
	localparam logic [7:0] OP_STA_ABSX = 8'h9D;
	localparam logic [7:0] OP_STA_ABSY = 8'h99;
	localparam logic [7:0] OP_STA_INDX = 8'h81;
	localparam logic [7:0] OP_STA_INDY = 8'h91;
	localparam logic [7:0] OP_STX_ZP   = 8'h86;
	localparam logic [7:0] OP_STX_ZPY  = 8'h96;
	localparam logic [7:0] OP_STX_ABS  = 8'h8E;
	localparam logic [7:0] OP_STY_ZP   = 8'h84;
	localparam logic [7:0] OP_STY_ZPX  = 8'h94;
	localparam logic [7:0] OP_STY_ABS  = 8'h8C;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  instruction_byte;
		logic [15:0] program_counter;
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  access_kind;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic [15:0] next_pc;
		logic [2:0]  cycles_taken;
		logic        done_res;
	} out_item_t;

	// Decoded instruction: the mode stands in for the held opcode.
	typedef struct packed {
		logic       ok;
		logic [2:0] mode;
		logic [1:0] src;
		logic [1:0] idx;
	} decode_t;

	// Architectural state carried between beats.
	typedef struct packed {
		logic [2:0]  phase;
		logic [2:0]  mode;
		logic [15:0] held_pc;
		logic [7:0]  store_value;
		logic [7:0]  index_value;
		logic [7:0]  addr_lo;
		logic [7:0]  zp_pointer;
	} exec_state_t;

	function automatic decode_t decode_op(input logic [7:0] op);
		decode_t d;
		d = '{ok: 1'b1, mode: M_ZP, src: REG_A, idx: REG_NONE};
		unique case (op)
			OP_STA_ZP:   d.mode = M_ZP;
			OP_STA_ZPX:  begin d.mode = M_ZPI;  d.idx = REG_X; end
			OP_STA_ABS:  d.mode = M_ABS;
			OP_STA_ABSX: begin d.mode = M_ABSI; d.idx = REG_X; end
			OP_STA_ABSY: begin d.mode = M_ABSI; d.idx = REG_Y; end
			OP_STA_INDX: begin d.mode = M_INDX; d.idx = REG_X; end
			OP_STA_INDY: begin d.mode = M_INDY; d.idx = REG_Y; end
			OP_STX_ZP:   begin d.mode = M_ZP;   d.src = REG_X; end
			OP_STX_ZPY:  begin d.mode = M_ZPI;  d.src = REG_X; d.idx = REG_Y; end
			OP_STX_ABS:  begin d.mode = M_ABS;  d.src = REG_X; end
			OP_STY_ZP:   begin d.mode = M_ZP;   d.src = REG_Y; end
			OP_STY_ZPX:  begin d.mode = M_ZPI;  d.src = REG_Y; d.idx = REG_X; end
			OP_STY_ABS:  begin d.mode = M_ABS;  d.src = REG_Y; end
			default:     d.ok = 1'b0;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] mode_cycles(input logic [2:0] mode);
		logic [2:0] c;
		unique case (mode)
			M_ZP:            c = 3'd3;
			M_ZPI, M_ABS:    c = 3'd4;
			M_ABSI:          c = 3'd5;
			default:         c = 3'd6;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] mode_length(input logic [2:0] mode);
		logic [1:0] l;
		unique case (mode)
			M_ABS, M_ABSI: l = 2'd3;
			default:       l = 2'd2;
		endcase
		return l;
	endfunction

endpackage

>>> src/siex_step.sv
module siex_step (
	input  siex_pkg::exec_state_t cur,
	input  siex_pkg::in_item_t    item,
	output siex_pkg::exec_state_t nxt,
	output logic                  emit,
	output siex_pkg::out_item_t   res
);
	import siex_pkg::*;

	decode_t     dec;
	logic [7:0]  data;
	logic [7:0]  zp_sum;
	logic [15:0] full_addr;
	logic [15:0] write_addr;
	logic        to_write;

	assign dec  = decode_op(item.instruction_byte);
	assign data = item.read_data;
	// Zero-page index add wraps at 8 bits.
	assign zp_sum = data + cur.index_value;
	// Operand or pointer high byte joined with the low byte already fetched.
	assign full_addr = {data, cur.addr_lo};

	// Next state and result for one beat.
	always_comb begin
		nxt        = cur;
		emit       = 1'b0;
		res        = '0;
		to_write   = 1'b0;
		write_addr = '0;
		if (item.opcode == ITEM_START) begin
			emit = 1'b1;
			if (!dec.ok) begin
				nxt.phase        = PH_IDLE;
				res.access_kind  = ACC_ERROR;
				res.next_pc      = item.program_counter;
				res.done_res     = 1'b1;
			end else begin
				nxt.phase   = PH_OPLO;
				nxt.mode    = dec.mode;
				nxt.held_pc = item.program_counter;
				unique case (dec.src)
					REG_X:   nxt.store_value = item.index_x;
					REG_Y:   nxt.store_value = item.index_y;
					default: nxt.store_value = item.accumulator;
				endcase
				unique case (dec.idx)
					REG_X:   nxt.index_value = item.index_x;
					REG_Y:   nxt.index_value = item.index_y;
					default: nxt.index_value = 8'd0;
				endcase
				nxt.addr_lo     = 8'd0;
				nxt.zp_pointer  = 8'd0;
				res.access_kind = ACC_READ;
				res.bus_address = item.program_counter + 16'd1;
			end
		end else begin
			unique case (cur.phase)
				PH_OPLO: begin
					emit = 1'b1;
					if (cur.mode == M_ZP || cur.mode == M_ZPI) begin
						to_write   = 1'b1;
						write_addr = {8'd0, zp_sum};
					end else if (cur.mode == M_ABS || cur.mode == M_ABSI) begin
						nxt.addr_lo     = data;
						nxt.phase       = PH_OPHI;
						res.access_kind = ACC_READ;
						res.bus_address = cur.held_pc + 16'd2;
					end else begin
						nxt.zp_pointer  = (cur.mode == M_INDX) ? zp_sum : data;
						nxt.phase       = PH_PTRLO;
						res.access_kind = ACC_READ;
						res.bus_address = {8'd0, nxt.zp_pointer};
					end
				end
				PH_OPHI: begin
					emit       = 1'b1;
					to_write   = 1'b1;
					write_addr = full_addr + {8'd0, cur.index_value};
				end
				PH_PTRLO: begin
					emit            = 1'b1;
					nxt.addr_lo     = data;
					nxt.phase       = PH_PTRHI;
					res.access_kind = ACC_READ;
					// The high pointer byte stays in page zero.
					res.bus_address = {8'd0, cur.zp_pointer + 8'd1};
				end
				PH_PTRHI: begin
					emit       = 1'b1;
					to_write   = 1'b1;
					write_addr = (cur.mode == M_INDY)
						? full_addr + {8'd0, cur.index_value} : full_addr;
				end
				default: begin
					// A read beat while idle is dropped.
					nxt.phase = PH_IDLE;
				end
			endcase
			// Final write access ends the instruction.
			if (to_write) begin
				nxt.phase        = PH_IDLE;
				res.access_kind  = ACC_WRITE;
				res.bus_address  = write_addr;
				res.write_data   = cur.store_value;
				res.next_pc      = cur.held_pc + {14'd0, mode_length(cur.mode)};
				res.cycles_taken = mode_cycles(cur.mode);
				res.done_res     = 1'b1;
			end
		end
	end

endmodule

>>> src/store_instruction_executor_unit.sv
// Executes the 6502 stores STA, STX and STY one bus beat at a time. A start
// beat latches the instruction and returns the first operand read request;
// each read-data beat returns the next read request or the final write, which
// carries the new PC and the cycle cost. Unknown opcodes return an error
// result at once. One input beat is taken every clock cycle; each beat goes
// through an input register and the decode/address logic, and any result it
// yields is registered in the output register. Back-pressure on the output
// only stalls the input once both registers hold a beat.
module store_instruction_executor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  siex_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output siex_pkg::out_item_t out_data
);
	import siex_pkg::*;

	in_item_t    item_s1;
	logic        valid_s1;
	exec_state_t state_q;
	exec_state_t state_next;
	logic        emit;
	out_item_t   res;
	out_item_t   out_q;
	logic        out_valid_q;
	logic        advance;

	// The input register moves on whenever the output register can take a beat.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	siex_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.emit (emit),
		.res  (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Instruction state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
